### design/sufc_pkg.sv
package sufc_pkg;

  // Item kinds on the request channel; code 3 does nothing
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  float_bus;
  } sufc_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [3:0] pulse1_level;
    logic [3:0] pulse2_level;
  } sufc_rsp_t;

  // Register map
  localparam logic [15:0] ADDR_P1_CTRL  = 16'h4000;
  localparam logic [15:0] ADDR_P1_LOW   = 16'h4002;
  localparam logic [15:0] ADDR_P1_HIGH  = 16'h4003;
  localparam logic [15:0] ADDR_P2_CTRL  = 16'h4004;
  localparam logic [15:0] ADDR_P2_LOW   = 16'h4006;
  localparam logic [15:0] ADDR_P2_HIGH  = 16'h4007;
  localparam logic [15:0] ADDR_TRI_LEN  = 16'h400B;
  localparam logic [15:0] ADDR_NOI_LEN  = 16'h400F;
  localparam logic [15:0] ADDR_STATUS   = 16'h4015;
  localparam logic [15:0] ADDR_FRAME    = 16'h4017;

  // Frame sequencer step points
  localparam logic [14:0] FRAME_STEP1 = 15'd3729;
  localparam logic [14:0] FRAME_STEP2 = 15'd7457;
  localparam logic [14:0] FRAME_STEP3 = 15'd11186;
  localparam logic [14:0] FRAME_STEP4 = 15'd14915;
  localparam logic [14:0] FRAME_STEP5 = 15'd18641;

  localparam logic [3:0]  ENV_MAX   = 4'd15;
  localparam logic [10:0] TIMER_MIN = 11'd8;

  // Per-item control for one pulse channel
  typedef struct packed {
    logic       tick;
    logic       quarter;
    logic       wr_ctrl;
    logic       wr_low;
    logic       wr_high;
    logic       enable;
    logic       len_active;
    logic [7:0] data;
  } pulse_ctl_t;

  // Frame sequencer events for the item in hand
  typedef struct packed {
    logic quarter;
    logic half;
    logic irq;
  } frame_ev_t;

  function automatic logic [7:0] len_load(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
      5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
      5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
      5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
      5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
      5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   5'd31: v = 8'd30;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] duty_wave(input logic [1:0] sel);
    logic [7:0] v;
    case (sel)
      2'd0:    v = 8'h02;
      2'd1:    v = 8'h06;
      2'd2:    v = 8'h1E;
      2'd3:    v = 8'hF9;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### design/sound_unit_pulse_frame_counter.sv
// Sound unit subset: two pulse channels, four length counters and the frame sequencer.
// Request channel (req_valid / req_stall / req): one item per transfer, either a clock
// tick, a register write or a status read; code 3 is ignored but still answered.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one response per request,
// in order, carrying the status byte (reads only), the frame interrupt (ticks only)
// and both pulse levels as they stand after the item.
// A request that is taken lands in the input register, is processed as it moves into
// the response register and its response is presented from there on.
// Throughput: one item per cycle unless the response stalls; frame counter, envelopes,
// length counters and pulse timers all update in one pass between the two registers.
// A stalled response holds the response register; the input register still takes one
// more request, then req_stall rises until the response moves on.
// Reset (rst, synchronous) clears all counters, flags and pulse state to zero and
// empties both registers.
module sound_unit_pulse_frame_counter
  import sufc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  sufc_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output sufc_rsp_t rsp
);

  logic       s1_valid;
  sufc_req_t  s1;
  logic       advance;
  logic       is_tick, is_wr, is_rd;
  logic       wr_frame, wr_enable;
  logic [3:0] wr_len;
  logic [7:0] len [4];
  logic [7:0] len_next [4];
  logic [3:0] len_nz;
  logic [4:0] enables, enables_next;
  logic [3:0] halt;
  logic       halt1, halt2;
  logic       pending;
  frame_ev_t  ev;
  pulse_ctl_t ctl1, ctl2;
  logic [3:0] level1, level2;
  sufc_rsp_t  rsp_next;

  // Handshake: input register feeds the response register
  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (!req_stall) s1_valid <= req_valid;
      if (advance) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) s1 <= req;
    if (advance) rsp <= rsp_next;
  end

  // Item decode
  always_comb begin
    is_tick   = advance && (s1.func == FUNC_TICK);
    is_wr     = advance && (s1.func == FUNC_WRITE);
    is_rd     = advance && (s1.func == FUNC_READ);
    wr_frame  = is_wr && (s1.addr == ADDR_FRAME);
    wr_enable = is_wr && (s1.addr == ADDR_STATUS);
    wr_len    = {is_wr && (s1.addr == ADDR_NOI_LEN), is_wr && (s1.addr == ADDR_TRI_LEN),
                 is_wr && (s1.addr == ADDR_P2_HIGH), is_wr && (s1.addr == ADDR_P1_HIGH)};
  end

  sufc_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .tick    (is_tick),
    .wr      (wr_frame),
    .rd      (is_rd),
    .data    (s1.data),
    .ev      (ev),
    .pending (pending)
  );

  // Length counters and enable mask
  assign halt = {2'b00, halt2, halt1};

  always_comb begin
    enables_next = wr_enable ? s1.data[4:0] : enables;
    for (int c = 0; c < 4; c++) begin
      len_nz[c]   = (len[c] != 8'd0);
      len_next[c] = len[c];
      if (wr_len[c] && enables[c]) len_next[c] = len_load(s1.data[7:3]);
      if (wr_enable && !s1.data[c]) len_next[c] = 8'd0;
      if (ev.half && enables[c] && len_nz[c] && !halt[c]) len_next[c] = len[c] - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enables <= '0;
      for (int c = 0; c < 4; c++) len[c] <= '0;
    end else begin
      enables <= enables_next;
      for (int c = 0; c < 4; c++) len[c] <= len_next[c];
    end
  end

  // Pulse channels
  always_comb begin
    ctl1.tick       = is_tick;
    ctl1.quarter    = ev.quarter;
    ctl1.wr_ctrl    = is_wr && (s1.addr == ADDR_P1_CTRL);
    ctl1.wr_low     = is_wr && (s1.addr == ADDR_P1_LOW);
    ctl1.wr_high    = wr_len[0];
    ctl1.enable     = enables[0];
    ctl1.len_active = (len_next[0] != 8'd0);
    ctl1.data       = s1.data;
    ctl2.tick       = is_tick;
    ctl2.quarter    = ev.quarter;
    ctl2.wr_ctrl    = is_wr && (s1.addr == ADDR_P2_CTRL);
    ctl2.wr_low     = is_wr && (s1.addr == ADDR_P2_LOW);
    ctl2.wr_high    = wr_len[1];
    ctl2.enable     = enables[1];
    ctl2.len_active = (len_next[1] != 8'd0);
    ctl2.data       = s1.data;
  end

  sufc_pulse u_pulse1 (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl1),
    .level_next (level1),
    .halt       (halt1)
  );

  sufc_pulse u_pulse2 (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl2),
    .level_next (level2),
    .halt       (halt2)
  );

  // Response
  always_comb begin
    rsp_next.read_data    = is_rd ? {1'b0, pending, s1.float_bus[5], enables[4], len_nz}
                                  : 8'd0;
    rsp_next.irq          = is_tick && ev.irq;
    rsp_next.pulse1_level = level1;
    rsp_next.pulse2_level = level2;
  end

  a_disabled_empty: assert property (@(posedge clk) disable iff (rst)
    (len_nz & ~enables[3:0]) == 4'd0)
    else $error("length counter running on a disabled channel");

  a_free_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("request stalled with the response register empty");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

### design/sufc_frame.sv
module sufc_frame
  import sufc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic       wr,
  input  logic       rd,
  input  logic [7:0] data,
  output frame_ev_t  ev,
  output logic       pending
);

  logic [14:0] count, count_next;
  logic        five, five_next;
  logic        inhibit, inhibit_next;
  logic        pending_next;
  logic [14:0] f;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      five    <= 1'b0;
      inhibit <= 1'b0;
      pending <= 1'b0;
    end else begin
      count   <= count_next;
      five    <= five_next;
      inhibit <= inhibit_next;
      pending <= pending_next;
    end
  end

  // Step decode and next state
  always_comb begin
    f            = count + 15'd1;
    count_next   = count;
    five_next    = five;
    inhibit_next = inhibit;
    pending_next = pending;
    ev           = '0;
    if (tick) begin
      ev.half    = (f == FRAME_STEP2) || (f == FRAME_STEP4);
      ev.quarter = ev.half || (f == FRAME_STEP1) || (f == FRAME_STEP3) ||
                   (five && (f == FRAME_STEP5));
      count_next = f;
      if (!five) begin
        if (f >= FRAME_STEP4) begin
          if (!inhibit) pending_next = 1'b1;
          count_next = '0;
        end
      end else if (f >= FRAME_STEP5) begin
        count_next = '0;
      end
      ev.irq = pending_next && !inhibit;
    end
    if (wr) begin
      five_next    = data[7];
      inhibit_next = data[6];
      if (data[6]) pending_next = 1'b0;
      count_next   = '0;
    end
    if (rd) pending_next = 1'b0;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < FRAME_STEP5)
    else $error("frame count past the last step");

  a_inhibit_clears: assert property (@(posedge clk) disable iff (rst)
    inhibit |-> !pending)
    else $error("interrupt pending while inhibited");

  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    rd |=> !pending)
    else $error("status read did not clear the interrupt");

endmodule

### design/sufc_pulse.sv
module sufc_pulse
  import sufc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  pulse_ctl_t ctl,
  output logic [3:0] level_next,
  output logic       halt
);

  logic [1:0]  duty, duty_next;
  logic        halt_next;
  logic        cvol, cvol_next;
  logic [3:0]  env_period, env_period_next;
  logic        env_start, env_start_next;
  logic [3:0]  decay, decay_next;
  logic [3:0]  divider, divider_next;
  logic [10:0] period, period_next;
  logic [10:0] count, count_next;
  logic [2:0]  step, step_next;
  logic [3:0]  level;
  logic [7:0]  wave;

  // Channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      duty       <= '0;
      halt       <= 1'b0;
      cvol       <= 1'b0;
      env_period <= '0;
      env_start  <= 1'b0;
      decay      <= '0;
      divider    <= '0;
      period     <= '0;
      count      <= '0;
      step       <= '0;
      level      <= '0;
    end else begin
      duty       <= duty_next;
      halt       <= halt_next;
      cvol       <= cvol_next;
      env_period <= env_period_next;
      env_start  <= env_start_next;
      decay      <= decay_next;
      divider    <= divider_next;
      period     <= period_next;
      count      <= count_next;
      step       <= step_next;
      level      <= level_next;
    end
  end

  // Register writes, envelope, timer and level
  always_comb begin
    duty_next       = duty;
    halt_next       = halt;
    cvol_next       = cvol;
    env_period_next = env_period;
    env_start_next  = env_start;
    decay_next      = decay;
    divider_next    = divider;
    period_next     = period;
    count_next      = count;
    step_next       = step;
    level_next      = level;
    wave            = duty_wave(duty);

    if (ctl.wr_ctrl) begin
      duty_next       = ctl.data[7:6];
      halt_next       = ctl.data[5];
      cvol_next       = ctl.data[4];
      env_period_next = ctl.data[3:0];
    end
    if (ctl.wr_low) period_next[7:0] = ctl.data;
    if (ctl.wr_high) begin
      period_next[10:8] = ctl.data[2:0];
      step_next         = '0;
      env_start_next    = 1'b1;
    end

    if (ctl.tick) begin
      // envelope on a quarter-frame clock
      if (ctl.quarter) begin
        if (env_start) begin
          env_start_next = 1'b0;
          decay_next     = ENV_MAX;
          divider_next   = env_period;
        end else if (divider != 4'd0) begin
          divider_next = divider - 4'd1;
        end else begin
          divider_next = env_period;
          if (decay != 4'd0) decay_next = decay - 4'd1;
          else if (halt)     decay_next = ENV_MAX;
        end
      end
      // timer reload steps the duty sequence
      if (count == 11'd0) begin
        count_next = period;
        step_next  = step + 3'd1;
      end else begin
        count_next = count - 11'd1;
      end
      if (!ctl.enable || !ctl.len_active || (period < TIMER_MIN) || !wave[step_next]) begin
        level_next = '0;
      end else begin
        level_next = cvol ? env_period : decay_next;
      end
    end
  end

endmodule
